// ----- hw/rtl/ptt_pkg.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer bank package
// Shared field widths, operation and status codes, and the control and
// status structs that link the controller to the datapath.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // Field widths of the input, result and configuration words.
  localparam int FUNC_W   = 3;
  localparam int SLOT_IN_W = 8;
  localparam int DELAY_W  = 32;
  localparam int STEP_W   = 16;
  localparam int STATUS_W = 3;
  localparam int GIVEN_W  = 3;
  localparam int MASK_W   = 8;

  // Tick step after reset, in microseconds.
  localparam logic [STEP_W-1:0] STEP_RESET = 16'd1000;

  // Operation codes carried in the func field.
  typedef enum logic [FUNC_W-1:0] {
    OP_ADD     = 3'd0,
    OP_DELETE  = 3'd1,
    OP_ENABLE  = 3'd2,
    OP_DISABLE = 3'd3,
    OP_TICK    = 3'd4,
    OP_COLLECT = 3'd5
  } op_t;

  // Status codes returned with every result word.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_SAME   = 3'd2,
    ST_NOTASK = 3'd3,
    ST_BADIDX = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the accepted input word
    logic exec;     // apply a single-step operation to the slot flags
    logic walk;     // advance the tick walk by one slot
    logic finish;   // load the result register
  } ptt_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic out_free;   // result register can take a new word this cycle
    logic walk_last;  // this walk step writes back the last slot
  } ptt_stat_t;

endpackage

// ----- hw/rtl/ptt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ptt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ----- hw/rtl/ptt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer bank controller
// Sequences one operation at a time: single-step operations, the tick walk
// over all slots, and the hand-off of each result word to the output register.
// ----------------------------------------------------------------------------
module ptt_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [ptt_pkg::FUNC_W-1:0]     in_func,
  output logic                           in_stall,
  input  ptt_pkg::ptt_stat_t             stat_i,
  output ptt_pkg::ptt_cmd_t              cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_TFIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd_o.capture = 1'b1;
          if (in_func == ptt_pkg::OP_TICK) begin
            state_nxt = S_WALK;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        // The operation is applied only once the result can be stored.
        if (stat_i.out_free) begin
          cmd_o.exec   = 1'b1;
          cmd_o.finish = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_last) begin
          if (stat_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            state_nxt = S_TFIN;
          end
        end
      end
      S_TFIN: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    in_stall_nxt = (state_nxt != S_IDLE);
  end

  // State and registered stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ----- hw/rtl/ptt_dp.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer bank datapath
// Holds the slot flags, the countdown and reload memories, the tick step
// register, the walk counter with its shared subtractor, and the result word.
// ----------------------------------------------------------------------------
module ptt_dp #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ptt_pkg::ptt_cmd_t                 cmd_i,
  output ptt_pkg::ptt_stat_t                stat_o,
  input  logic [ptt_pkg::FUNC_W-1:0]        in_func,
  input  logic [ptt_pkg::SLOT_IN_W-1:0]     in_slot,
  input  logic [ptt_pkg::DELAY_W-1:0]       in_delay_us,
  input  logic                              cfg_wr_en,
  input  logic [ptt_pkg::STEP_W-1:0]        cfg_wr_data,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [ptt_pkg::STATUS_W-1:0]      out_status,
  output logic [ptt_pkg::GIVEN_W-1:0]       out_given_slot,
  output logic [ptt_pkg::MASK_W-1:0]        out_pending_mask
);

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam logic [ptt_pkg::SLOT_IN_W-1:0] NUM_SLOTS_IN = ptt_pkg::SLOT_IN_W'(NUM_SLOTS);
  localparam logic [CNT_W-1:0] NUM_SLOTS_CNT = CNT_W'(NUM_SLOTS);

  // Captured input word.
  logic [ptt_pkg::FUNC_W-1:0]    op_r;
  logic [ptt_pkg::SLOT_IN_W-1:0] slot_r;
  logic [ptt_pkg::DELAY_W-1:0]   delay_r;

  // Slot flags and occupancy count.
  logic [NUM_SLOTS-1:0] used_r, used_nxt;
  logic [NUM_SLOTS-1:0] act_r, act_nxt;
  logic [NUM_SLOTS-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0]     used_cnt_r, used_cnt_nxt;

  // Tick step register.
  logic [ptt_pkg::STEP_W-1:0] step_r;

  // Walk counter and write-back stage.
  logic [CNT_W-1:0]  walk_cnt_r, walk_cnt_nxt;
  logic              wr_vld_r, wr_vld_nxt;
  logic [SLOT_W-1:0] wr_idx_r;
  logic [SLOT_W-1:0] rd_addr;

  // Memory ports.
  logic [ptt_pkg::DELAY_W-1:0] cd_rd, rl_rd, cd_new, cd_wdata;
  logic [SLOT_W-1:0]           cd_waddr;
  logic                        cd_we, rl_we;
  logic [ptt_pkg::DELAY_W-1:0] step_ext;

  // Decode helpers.
  logic              found;
  logic [SLOT_W-1:0] free_idx;
  logic              slot_ok;
  logic [SLOT_W-1:0] sidx;
  logic              is_en;
  logic              walk_hit;

  // Result word and output register.
  logic [ptt_pkg::STATUS_W-1:0] res_status;
  logic [ptt_pkg::GIVEN_W-1:0]  res_given;
  logic [ptt_pkg::MASK_W-1:0]   pend_mask;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free;

  // Lowest free slot.
  always_comb begin
    int i;
    found    = 1'b0;
    free_idx = '0;
    for (i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        found    = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  assign slot_ok = (slot_r < NUM_SLOTS_IN);
  assign sidx    = slot_r[SLOT_W-1:0];
  assign is_en   = (op_r == ptt_pkg::OP_ENABLE);

  // Pending flags as seen in the eight-bit mask.
  for (genvar b = 0; b < ptt_pkg::MASK_W; b++) begin : g_mask
    if (b < NUM_SLOTS) begin : g_on
      assign pend_mask[b] = pend_r[b];
    end else begin : g_off
      assign pend_mask[b] = 1'b0;
    end
  end

  // Result word for the captured operation, taken from the state before it.
  always_comb begin
    res_status = ptt_pkg::ST_OK;
    res_given  = '0;
    case (op_r)
      ptt_pkg::OP_ADD: begin
        if (found) begin
          res_given = ptt_pkg::GIVEN_W'(free_idx);
        end else begin
          res_status = ptt_pkg::ST_FULL;
        end
      end
      ptt_pkg::OP_DELETE: begin
        if (!slot_ok) begin
          res_status = ptt_pkg::ST_BADIDX;
        end
      end
      ptt_pkg::OP_ENABLE, ptt_pkg::OP_DISABLE: begin
        if (!slot_ok) begin
          res_status = ptt_pkg::ST_BADIDX;
        end else if (!used_r[sidx]) begin
          res_status = ptt_pkg::ST_NOTASK;
        end else if (act_r[sidx] == is_en) begin
          res_status = ptt_pkg::ST_SAME;
        end
      end
      default: begin
        res_status = ptt_pkg::ST_OK;
      end
    endcase
  end

  // Walk: read slot n while slot n-1 is written back.
  assign rd_addr      = walk_cnt_r[SLOT_W-1:0];
  assign walk_cnt_nxt = cmd_i.capture ? '0 :
                        cmd_i.walk    ? walk_cnt_r + 1'b1 : walk_cnt_r;
  assign wr_vld_nxt   = cmd_i.walk && (walk_cnt_r < NUM_SLOTS_CNT);
  assign walk_hit     = wr_vld_r && act_r[wr_idx_r] && !pend_r[wr_idx_r];

  // Shared saturating subtractor, or reload when the countdown has expired.
  assign step_ext = {{(ptt_pkg::DELAY_W - ptt_pkg::STEP_W){1'b0}}, step_r};
  always_comb begin
    if (cd_rd == '0) begin
      cd_new = rl_rd;
    end else if (cd_rd > step_ext) begin
      cd_new = cd_rd - step_ext;
    end else begin
      cd_new = '0;
    end
  end

  // Memory write selection: add loads both memories, the walk writes back.
  always_comb begin
    rl_we    = cmd_i.exec && (op_r == ptt_pkg::OP_ADD) && found;
    cd_we    = rl_we || walk_hit;
    cd_waddr = rl_we ? free_idx : wr_idx_r;
    cd_wdata = rl_we ? delay_r : cd_new;
  end

  // Flag and count updates.
  always_comb begin
    used_nxt     = used_r;
    act_nxt      = act_r;
    pend_nxt     = pend_r;
    used_cnt_nxt = used_cnt_r;
    if (cmd_i.exec) begin
      case (op_r)
        ptt_pkg::OP_ADD: begin
          if (found) begin
            used_nxt[free_idx] = 1'b1;
            act_nxt[free_idx]  = 1'b1;
            pend_nxt[free_idx] = 1'b0;
            used_cnt_nxt       = used_cnt_r + 1'b1;
          end
        end
        ptt_pkg::OP_DELETE: begin
          if (slot_ok) begin
            if (used_r[sidx] && (used_cnt_r != '0)) begin
              used_cnt_nxt = used_cnt_r - 1'b1;
            end
            used_nxt[sidx] = 1'b0;
            act_nxt[sidx]  = 1'b0;
            pend_nxt[sidx] = 1'b0;
          end
        end
        ptt_pkg::OP_ENABLE, ptt_pkg::OP_DISABLE: begin
          if (slot_ok && used_r[sidx]) begin
            act_nxt[sidx] = is_en;
          end
        end
        ptt_pkg::OP_COLLECT: begin
          pend_nxt = '0;
        end
        default: begin
          used_nxt = used_r;
        end
      endcase
    end
    if (walk_hit && (cd_rd == '0)) begin
      pend_nxt[wr_idx_r] = 1'b1;
    end
  end

  // Output register: loaded on finish, cleared when taken.
  assign out_free = !out_valid_r || !out_stall;
  always_comb begin
    if (cmd_i.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      act_r       <= '0;
      pend_r      <= '0;
      used_cnt_r  <= '0;
      step_r      <= ptt_pkg::STEP_RESET;
      walk_cnt_r  <= '0;
      wr_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      act_r       <= act_nxt;
      pend_r      <= pend_nxt;
      used_cnt_r  <= used_cnt_nxt;
      walk_cnt_r  <= walk_cnt_nxt;
      wr_vld_r    <= wr_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      op_r    <= in_func;
      slot_r  <= in_slot;
      delay_r <= in_delay_us;
    end
    wr_idx_r <= rd_addr;
    if (cmd_i.finish) begin
      out_status       <= res_status;
      out_given_slot   <= res_given;
      out_pending_mask <= (op_r == ptt_pkg::OP_COLLECT) ? pend_mask : '0;
    end
  end

  // Countdown and reload memories.
  ptt_ram #(
    .WIDTH (ptt_pkg::DELAY_W),
    .DEPTH (NUM_SLOTS)
  ) u_cd_ram (
    .clk     (clk),
    .wr_en   (cd_we),
    .wr_addr (cd_waddr),
    .wr_data (cd_wdata),
    .rd_addr (rd_addr),
    .rd_data (cd_rd)
  );

  ptt_ram #(
    .WIDTH (ptt_pkg::DELAY_W),
    .DEPTH (NUM_SLOTS)
  ) u_rl_ram (
    .clk     (clk),
    .wr_en   (rl_we),
    .wr_addr (free_idx),
    .wr_data (delay_r),
    .rd_addr (rd_addr),
    .rd_data (rl_rd)
  );

  assign out_valid        = out_valid_r;
  assign stat_o.out_free  = out_free;
  assign stat_o.walk_last = (walk_cnt_r == NUM_SLOTS_CNT);

`ifndef NO_ASSERTIONS
  // The occupancy count always matches the number of used slots.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    used_cnt_r == CNT_W'($countones(used_r)))
    else $error("used count out of step with used flags");

  // Only used slots can be active or pending.
  a_act_used: assert property (@(posedge clk) disable iff (!rst_n)
    ((act_r | pend_r) & ~used_r) == '0)
    else $error("active or pending flag on an unused slot");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.finish |-> out_free)
    else $error("result register overwritten");

  // A write-back follows a walk step.
  a_wb_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wr_vld_r |-> $past(cmd_i.walk))
    else $error("write-back without a walk step");

  // Add and the walk never share the countdown write port.
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(rl_we && wr_vld_r))
    else $error("countdown write port conflict");
`endif

endmodule

// ----- hw/rtl/periodic_task_timer_bank_core.sv -----
// ----------------------------------------------------------------------------
// Periodic task timer bank
// A bank of periodic timer slots with add, delete, enable, disable, tick and
// collect operations; each input word yields one result word.
//
//   Channel  Ports                                         Direction
//   -------  --------------------------------------------  ---------
//   input    in_valid, in_stall, in_func, in_slot,         in
//            in_delay_us
//   result   out_valid, out_stall, out_status,             out
//            out_given_slot, out_pending_mask
//   config   cfg_wr_en, cfg_wr_data (tick step in us)      in
//
// Add, delete, enable, disable and collect are captured, then applied as the
// result is loaded. A tick walks the slots with one subtractor through the
// countdown memory, reading one slot while the previous one is written back.
// One word is worked at a time; the next is accepted as soon as the result
// is in the output register, even if that word is still waiting. A stall on
// the result side holds the finished word and delays the next one at its
// final step. Reset is synchronous and clears all slots.
// ----------------------------------------------------------------------------
module periodic_task_timer_bank_core #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ptt_pkg::FUNC_W-1:0]        in_func,
  input  logic [ptt_pkg::SLOT_IN_W-1:0]     in_slot,
  input  logic [ptt_pkg::DELAY_W-1:0]       in_delay_us,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ptt_pkg::STATUS_W-1:0]      out_status,
  output logic [ptt_pkg::GIVEN_W-1:0]       out_given_slot,
  output logic [ptt_pkg::MASK_W-1:0]        out_pending_mask,
  input  logic                              cfg_wr_en,
  input  logic [ptt_pkg::STEP_W-1:0]        cfg_wr_data
);

  ptt_pkg::ptt_cmd_t  cmd;
  ptt_pkg::ptt_stat_t stat;

  // Operation sequencer.
  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // Slot state, arithmetic and result register.
  ptt_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .in_func          (in_func),
    .in_slot          (in_slot),
    .in_delay_us      (in_delay_us),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_given_slot   (out_given_slot),
    .out_pending_mask (out_pending_mask)
  );

endmodule
